@@ hw/rtl/sha256_block_hash_core_defines.svh @@
// Assertion macros shared by the SHA-256 hash core RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef SHA256_BLOCK_HASH_CORE_DEFINES_SVH
`define SHA256_BLOCK_HASH_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define SHA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SHA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/sha256bh_pkg.sv @@
// Shared types, constants and sigma functions of the SHA-256 hash core.
// Used by every RTL module of the core; depends on nothing.
`default_nettype none

package sha256bh_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned BlockWords  = 16;
   localparam int unsigned NumRounds   = 64;
   localparam int unsigned DigestWords = 8;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      logic [31:0] message_word;
      logic        final_word;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } rsp_payload_type;

   // Control from the sequencer to the schedule window and the round unit.
   typedef struct packed {
      logic shift_word;   // take a message word into the window
      logic expand;       // advance the window by one expanded word
      logic load_vars;    // copy the chaining value into a..h
      logic round_step;   // run one compression round
   } ctrl_type;

   localparam word_type InitHash [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [NumRounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha256bh_sched.sv @@
// Message schedule window: a 16-word shift line that takes message words
// and then expands W[t+16] each round. Depends on sha256bh_pkg.
`default_nettype none

module sha256bh_sched
   import sha256bh_pkg::*;
(
   input  wire logic     clock,
   input  wire ctrl_type ctrl,
   input  wire word_type word_in,
   output      word_type w_out
);

   word_type window_ff [BlockWords];
   word_type window_in [BlockWords];
   word_type expanded;

   // Window holds W[t] .. W[t+15] at places 0 .. 15.
   assign expanded = small_sigma1(window_ff[14]) + window_ff[9]
                   + small_sigma0(window_ff[1]) + window_ff[0];

   always_comb begin
      for (int i = 0; i < BlockWords - 1; i++) begin
         window_in[i] = (ctrl.shift_word || ctrl.expand) ? window_ff[i+1] : window_ff[i];
      end
      priority if (ctrl.shift_word) begin
         window_in[BlockWords-1] = word_in;
      end else if (ctrl.expand) begin
         window_in[BlockWords-1] = expanded;
      end else begin
         window_in[BlockWords-1] = window_ff[BlockWords-1];
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign w_out = window_ff[0];

endmodule

`default_nettype wire

@@ hw/rtl/sha256bh_round.sv @@
// Compression round unit: working variables a..h and one SHA-256 round
// per step. Depends on sha256bh_pkg.
`default_nettype none

module sha256bh_round
   import sha256bh_pkg::*;
(
   input  wire logic     clock,
   input  wire ctrl_type ctrl,
   input  wire word_type chain_value [DigestWords],
   input  wire word_type w_t,
   input  wire word_type k_t,
   output      word_type vars [DigestWords]
);

   word_type vars_ff [DigestWords];
   word_type vars_in [DigestWords];
   word_type t1;
   word_type t2;

   assign t1 = vars_ff[7] + big_sigma1(vars_ff[4])
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6])) + k_t + w_t;
   assign t2 = big_sigma0(vars_ff[0])
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
               ^ (vars_ff[1] & vars_ff[2]));

   always_comb begin
      priority if (ctrl.load_vars) begin
         vars_in = chain_value;
      end else if (ctrl.round_step) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end else begin
         vars_in = vars_ff;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   assign vars = vars_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sha256_block_hash_core.sv @@
// SHA-256 block hash core. Feed a message that software has already padded
// to the standard SHA-256 layout, one big-endian 32-bit word per request,
// with final_word set on the last word of the last block (the mark counts
// only on the sixteenth word of a block). The core takes one word per cycle
// while it collects a block; after the sixteenth word it stalls requests
// through 64 compression rounds, one per cycle on a single shared round
// unit, and through the step that adds the result into the chaining value.
// When the final block is done, the digest leaves as eight responses, most
// significant word first, one per cycle unless the receiver stalls;
// requests stay stalled until the eighth is taken, and the chaining value
// then returns to the standard initial hash.
// Depends on sha256bh_pkg, sha256bh_sched, sha256bh_round and the defines header.
`default_nettype none
`include "sha256_block_hash_core_defines.svh"

module sha256_block_hash_core
   import sha256bh_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,

   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,

   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_COLLECT,   // take message words
      ST_ROUND,     // run the 64 rounds
      ST_ADD,       // fold a..h into the chaining value
      ST_DIGEST     // hand out the eight digest words
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        final_ff, final_in;
   word_type    chain_ff [DigestWords];
   word_type    chain_in [DigestWords];

   word_type    vars [DigestWords];
   word_type    w_t;
   ctrl_type    ctrl;
   logic        req_accept;
   logic        rsp_accept;
   logic        block_end;
   logic        digest_done;

   assign req_stall   = (state_ff != ST_COLLECT);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = (state_ff == ST_DIGEST);
   assign rsp_accept  = rsp_valid && !rsp_stall;
   assign block_end   = req_accept && (pos_ff == 4'(BlockWords - 1));
   assign digest_done = rsp_accept && (idx_ff == 3'(DigestWords - 1));

   // Window shifts on each word and keeps expanding through the rounds;
   // a..h load from the chaining value as the block's last word arrives.
   always_comb begin
      ctrl.shift_word = req_accept;
      ctrl.expand     = (state_ff == ST_ROUND);
      ctrl.load_vars  = block_end;
      ctrl.round_step = (state_ff == ST_ROUND);
   end

   sha256bh_sched u_sched (
      .clock   (clock),
      .ctrl    (ctrl),
      .word_in (req_payload.message_word),
      .w_out   (w_t)
   );

   sha256bh_round u_round (
      .clock       (clock),
      .ctrl        (ctrl),
      .chain_value (chain_ff),
      .w_t         (w_t),
      .k_t         (RoundK[round_ff]),
      .vars        (vars)
   );

   // Digest word comes straight from the chaining registers, which hold
   // still while a response waits.
   assign rsp_payload.digest_word  = chain_ff[idx_ff];
   assign rsp_payload.digest_index = idx_ff;
   assign rsp_payload.digest_last  = (idx_ff == 3'(DigestWords - 1));

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      final_in = final_ff;
      chain_in = chain_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_accept) begin
               pos_in = pos_ff + 4'd1;
            end
            if (block_end) begin
               // Latch the final mark only on the block's last word.
               final_in = req_payload.final_word;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(NumRounds - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < DigestWords; i++) begin
               chain_in[i] = chain_ff[i] + vars[i];
            end
            idx_in   = '0;
            state_in = final_ff ? ST_DIGEST : ST_COLLECT;
         end
         ST_DIGEST: begin
            if (rsp_accept) begin
               idx_in = idx_ff + 3'd1;
            end
            if (digest_done) begin
               // Restart the chain for the next message.
               chain_in = InitHash;
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         pos_ff   <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         final_ff <= 1'b0;
         chain_ff <= InitHash;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         final_ff <= final_in;
         chain_ff <= chain_in;
      end
   end

   `SHA_ASSERT_SAME(a_no_req_during_digest, clock, reset, rsp_valid, req_stall, "request taken while digest pending")
   `SHA_ASSERT_NEXT(a_block_starts_rounds, clock, reset, block_end, (state_ff == ST_ROUND) && (round_ff == 6'd0), "block end did not start rounds")
   `SHA_ASSERT_NEXT(a_rounds_end_in_add, clock, reset, (state_ff == ST_ROUND) && (round_ff == 6'(NumRounds - 1)), state_ff == ST_ADD, "round count overran")
   `SHA_ASSERT_NEXT(a_mid_message_no_rsp, clock, reset, (state_ff == ST_ADD) && !final_ff, !rsp_valid && !req_stall, "non-final block produced output")
   `SHA_ASSERT_NEXT(a_chain_restart, clock, reset, digest_done, !req_stall && (chain_ff[0] == InitHash[0]), "chain not restarted after digest")

endmodule

`default_nettype wire
